### rtl/mvt_pkg.sv
// shared types and constants of the matrix-vector transform
package mvt_pkg;

    localparam int DATA_W      = 32;
    localparam int VEC_LEN     = 4;
    localparam int NUM_LANES   = 4;
    localparam int NUM_REGS    = 8;
    localparam int REG_W       = 64;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int ADDR_W      = REG_IDX_W + 3;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int LANE_STAGES = 4;

    typedef logic signed [DATA_W-1:0] data_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        data_t value;
        logic  sat;
    } lane_res_t;

endpackage

### rtl/mvt_lane.sv
// one row lane: four products, two-level add, shift and saturate
module mvt_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  mvt_pkg::data_t     coef [mvt_pkg::VEC_LEN],
    input  mvt_pkg::data_t     vec  [mvt_pkg::VEC_LEN],
    output mvt_pkg::lane_res_t res
);
    import mvt_pkg::*;

    localparam int PAIR_W = PROD_W + 1;
    localparam int HEAD_W = SUM_W - DATA_W + 1;

    logic signed [PROD_W-1:0] prod_reg [VEC_LEN];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [SUM_W-1:0]  sum_reg;
    lane_res_t                res_reg;

    logic signed [SUM_W-1:0]  shifted;
    logic                     fits;
    lane_res_t                res_next;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < VEC_LEN; j++)
        begin
            prod_reg[j] <= coef[j] * vec[j];
        end
        pair_reg[0] <= {prod_reg[0][PROD_W-1], prod_reg[0]}
                     + {prod_reg[1][PROD_W-1], prod_reg[1]};
        pair_reg[1] <= {prod_reg[2][PROD_W-1], prod_reg[2]}
                     + {prod_reg[3][PROD_W-1], prod_reg[3]};
        sum_reg     <= {pair_reg[0][PAIR_W-1], pair_reg[0]}
                     + {pair_reg[1][PAIR_W-1], pair_reg[1]};
        res_reg     <= res_next;
    end

    // floor shift, then clamp when the upper bits are not all sign
    always_comb
    begin
        shifted = sum_reg >>> FRAC_BITS;
        fits    = (shifted[SUM_W-1:DATA_W-1] == {HEAD_W{shifted[DATA_W-1]}});
        res_next.sat = !fits;
        if (fits)
        begin
            res_next.value = shifted[DATA_W-1:0];
        end
        else if (shifted[SUM_W-1])
        begin
            res_next.value = DATA_MIN;
        end
        else
        begin
            res_next.value = DATA_MAX;
        end
    end

    assign res = res_reg;

endmodule

### rtl/mvt_merge.sv
// gathers the lane results into one output beat with a combined clip flag
module mvt_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    input  mvt_pkg::lane_res_t lane [mvt_pkg::NUM_LANES],
    output mvt_pkg::data_t     res  [mvt_pkg::NUM_LANES],
    output logic               clipped,
    output logic               done
);
    import mvt_pkg::*;

    data_t res_reg [NUM_LANES];
    logic  clipped_reg;
    logic  clipped_next;
    logic  done_reg;

    always_comb
    begin
        clipped_next = 1'b0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            clipped_next = clipped_next | lane[i].sat;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            res_reg[i] <= lane[i].value;
        end
        clipped_reg <= clipped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid;
        end
    end

    assign res     = res_reg;
    assign clipped = clipped_reg;
    assign done    = done_reg;

endmodule

### rtl/matrix_vector_transform_core.sv
// top level of the 4x4 matrix by vector transform
//
// usage
//   a vector beat (vec_x..vec_w, signed q-format) is taken at a rising edge
//   with start high and busy low; busy stays low, so one beat per clock
//   four row lanes each form one dot product at full width, floor-shift it
//   by FRAC_BITS and clamp it to 32 bits; the merge stage registers the four
//   elements and ors the clamp flags into clipped
//   done pulses for one cycle once the beat has passed the lane pipeline and
//   the merge register, with res_x..res_w and clipped valid in that cycle only
//   throughput: one vector per clock, set by the per-lane pipeline of
//   multiply, pair add, final add and shift/clamp, plus the merge register
//   the receiver cannot stall: a result not taken in its done cycle is gone
//   matrix: eight 64-bit apb registers at byte address 8*i, two coefficients
//   each (low half even column, high half odd column); write them only while
//   no vector is in flight
//   reset: the matrix returns to identity and the pipeline empties, so no
//   done pulse shows up from beats taken before reset
module matrix_vector_transform_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // vector channel
    input  logic                        start,
    output logic                        busy,
    input  logic signed [31:0]          vec_x,
    input  logic signed [31:0]          vec_y,
    input  logic signed [31:0]          vec_z,
    input  logic signed [31:0]          vec_w,
    // result channel
    output logic                        done,
    output logic signed [31:0]          res_x,
    output logic signed [31:0]          res_y,
    output logic signed [31:0]          res_z,
    output logic signed [31:0]          res_w,
    output logic                        clipped,
    // matrix register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mvt_pkg::ADDR_W-1:0]  paddr,
    input  logic [mvt_pkg::REG_W-1:0]   pwdata,
    output logic [mvt_pkg::REG_W-1:0]   prdata,
    output logic                        pready
);
    import mvt_pkg::*;

    // identity reset: diagonal coefficients are one in the chosen q-format
    localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_BITS;
    localparam logic [REG_W-1:0] ONE_HI = ONE_LO << DATA_W;
    localparam logic [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
        ONE_LO, '0, ONE_HI, '0, '0, ONE_LO, '0, ONE_HI
    };

    logic [REG_W-1:0]     cfg_reg [NUM_REGS];
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;
    logic                 accept;
    logic [LANE_STAGES-1:0] vld_reg;

    data_t     vec      [VEC_LEN];
    data_t     lane_coef [NUM_LANES][VEC_LEN];
    lane_res_t lane_res  [NUM_LANES];
    data_t     res       [NUM_LANES];

    // apb register file, zero wait states
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign prdata  = cfg_reg[cfg_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_wr)
        begin
            cfg_reg[cfg_idx] <= pwdata;
        end
    end

    // no back-pressure anywhere: every start is a taken beat
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // valid travels alongside the lane pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LANE_STAGES-2:0], accept};
        end
    end

    assign vec[0] = vec_x;
    assign vec[1] = vec_y;
    assign vec[2] = vec_z;
    assign vec[3] = vec_w;

    // row r uses registers 2r (columns 0, 1) and 2r+1 (columns 2, 3)
    always_comb
    begin
        for (int r = 0; r < NUM_LANES; r++)
        begin
            for (int c = 0; c < VEC_LEN; c++)
            begin
                if (c[0])
                begin
                    lane_coef[r][c] = cfg_reg[REG_IDX_W'(r * 2 + (c >> 1))][REG_W-1:DATA_W];
                end
                else
                begin
                    lane_coef[r][c] = cfg_reg[REG_IDX_W'(r * 2 + (c >> 1))][DATA_W-1:0];
                end
            end
        end
    end

    for (genvar r = 0; r < NUM_LANES; r++)
    begin : g_lane
        mvt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .coef (lane_coef[r]),
            .vec  (vec),
            .res  (lane_res[r])
        );
    end

    mvt_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (vld_reg[LANE_STAGES-1]),
        .lane    (lane_res),
        .res     (res),
        .clipped (clipped),
        .done    (done)
    );

    assign res_x = res[0];
    assign res_y = res[1];
    assign res_z = res[2];
    assign res_w = res[3];

    // every taken beat comes out as a done pulse
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("taken beat produced no result");

    // no result without an earlier taken beat
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 5))
        else $error("result without a taken beat");

    // a clip flag means at least one element sits at a rail
    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && clipped) |->
            (res_x == DATA_MAX || res_x == DATA_MIN || res_y == DATA_MAX ||
             res_y == DATA_MIN || res_z == DATA_MAX || res_z == DATA_MIN ||
             res_w == DATA_MAX || res_w == DATA_MIN))
        else $error("clip flag with no saturated element");

endmodule
